// ===== design/chtk_pkg.sv =====
// Shared constants and types for the chained hash table.
package chtk_pkg;
    localparam int BUCKETS    = 4096;
    localparam int POOL_NODES = 8192;
    localparam int BW = $clog2(BUCKETS);
    localparam int NW = $clog2(POOL_NODES);
    localparam int CW = $clog2(POOL_NODES + 1);
    // node word: key_low, key_high, bit, link valid, link
    typedef struct packed {
        logic [63:0]   key_low;
        logic [63:0]   key_high;
        logic          nbit;
        logic          lvalid;
        logic [NW-1:0] link;
    } t_node;
    typedef struct packed {
        logic          valid;
        logic [NW-1:0] idx;
    } t_head;
endpackage

// ===== design/chained_hash_table_128bit_key.sv =====
// Hash table top level: bucket heads, node pool and the walk sequencer.
// Sequence: a taken word reads its bucket head (S_HEAD), then visits each chain node
// with a node read (S_NODE) and a compare (S_CMP); o_valid is registered in S_DONE.
// One word at a time: o_stall is high outside S_IDLE, so the next word is taken only
// after the result is registered and S_DONE returns to S_IDLE; a stalled output holds S_DONE.
// Reset (synchronous, active low) sets the state to S_CLR and clears the pool count and
// output valid, then a clearing pass empties all 4096 bucket heads while the input is stalled.
module chained_hash_table_128bit_key import chtk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [63:0] i_key_low,
    input  logic [63:0] i_key_high,
    input  logic        i_write_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_read_value,
    output logic        o_was_present,
    output logic        o_status
);
    localparam logic [2:0] S_IDLE = 3'd0, S_HEAD = 3'd1, S_NODE = 3'd2,
                           S_CMP = 3'd3, S_DONE = 3'd4, S_CLR = 3'd5;

    logic [2:0]    r_state, n_state;
    logic          r_mode, r_wv;
    logic [63:0]   r_lo, r_hi;
    logic [BW-1:0] r_b;
    logic [BW-1:0] r_clr;
    logic [NW-1:0] r_cur, r_prev;
    logic          r_have_prev;
    logic          r_hv;
    logic [CW-1:0] r_used;
    logic          r_ovalid, r_rv, r_pr, r_st;

    t_head         m_head [BUCKETS];
    t_node         m_node [POOL_NODES];
    t_head         r_head_q;
    t_node         r_node_q;
    t_node         r_prev_node;

    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [BW-1:0] head_ra;
    t_head         head_wd;
    logic          node_we;
    logic [NW-1:0] node_wa;
    t_node         node_wd;
    logic [NW-1:0] node_ra;

    logic    out_free, match, full;
    t_node   newn;

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign match    = (r_node_q.key_low == r_lo) && (r_node_q.key_high == r_hi);
    assign full     = (r_used >= CW'(POOL_NODES));
    assign newn     = '{key_low: r_lo, key_high: r_hi, nbit: r_mode,
                        lvalid: 1'b0, link: '0};

    // read the heads and nodes through registered outputs
    always_ff @(posedge i_clk) begin
        r_head_q <= m_head[head_ra];
        r_node_q <= m_node[node_ra];
        if (head_we) m_head[head_wa] <= head_wd;
        if (node_we) m_node[node_wa] <= node_wd;
    end

    // sequence the clearing pass, the walk and the write-back
    always_comb begin
        n_state = r_state;
        head_we = 1'b0;
        head_wa = r_b;
        head_ra = (r_state == S_IDLE) ? i_key_low[BW-1:0] : r_b;
        head_wd = '{valid: 1'b0, idx: '0};
        node_we = 1'b0;
        node_wa = r_used[NW-1:0];
        node_wd = newn;
        node_ra = r_cur;
        case (r_state)
            S_CLR: begin
                head_we = 1'b1;
                head_wa = r_clr;
                if (r_clr == BW'(BUCKETS - 1)) n_state = S_IDLE;
            end
            S_IDLE: if (i_valid) n_state = S_HEAD;
            S_HEAD: n_state = r_head_q.valid ? S_NODE : S_DONE;
            S_NODE: n_state = S_CMP;
            S_CMP:  n_state = (match || !r_node_q.lvalid) ? S_DONE : S_NODE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // append a fresh node for an absent key when there is room
        if (r_state == S_DONE && out_free && !r_st && !r_pr && (!r_mode || r_wv)) begin
            node_we = 1'b1;
            if (!r_hv) begin
                head_we = 1'b1;
                head_wd = '{valid: 1'b1, idx: r_used[NW-1:0]};
            end
        end
        // tail link and node updates happen in the compare cycle
        if (r_state == S_CMP) begin
            if (match && r_mode && r_wv) begin
                node_we = 1'b1; node_wa = r_cur;
                node_wd = r_node_q; node_wd.nbit = 1'b1;
            end else if (match && r_mode && !r_wv) begin
                if (r_have_prev) begin
                    node_we = 1'b1; node_wa = r_prev;
                    node_wd = r_prev_node;
                    node_wd.lvalid = r_node_q.lvalid;
                    node_wd.link   = r_node_q.link;
                end else begin
                    head_we = 1'b1;
                    head_wd = '{valid: r_node_q.lvalid, idx: r_node_q.link};
                end
            end else if (!match && !r_node_q.lvalid && !full &&
                         (!r_mode || r_wv)) begin
                node_we = 1'b1; node_wa = r_cur;
                node_wd = r_node_q; node_wd.lvalid = 1'b1;
                node_wd.link = r_used[NW-1:0];
            end
        end
    end

    // control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + BW'(1);
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
                if (node_we) r_used <= r_used + CW'(1);
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
        case (r_state)
            S_IDLE: if (i_valid) begin
                r_mode <= i_mode; r_wv <= i_write_value;
                r_lo <= i_key_low; r_hi <= i_key_high;
                r_b <= i_key_low[BW-1:0];
                r_have_prev <= 1'b0;
                r_pr <= 1'b0; r_rv <= 1'b0; r_st <= 1'b0;
            end
            S_HEAD: begin
                r_cur <= r_head_q.idx;
                r_hv  <= r_head_q.valid;
                if (!r_head_q.valid) begin
                    if (!r_mode || r_wv) begin
                        r_st <= full; r_rv <= full ? 1'b0 : r_mode;
                    end
                end
            end
            S_CMP: begin
                if (match) begin
                    r_pr <= 1'b1;
                    r_rv <= r_mode ? r_wv : r_node_q.nbit;
                end else if (!r_node_q.lvalid) begin
                    if (!r_mode || r_wv) begin
                        r_st <= full; r_rv <= full ? 1'b0 : r_mode;
                    end
                end else begin
                    // keep the previous node word for an unlink
                    r_prev <= r_cur; r_have_prev <= 1'b1;
                    r_prev_node <= r_node_q;
                    r_cur <= r_node_q.link;
                end
            end
            default: ;
        endcase
        if (r_state == S_DONE && out_free) begin
            o_read_value <= r_rv; o_was_present <= r_pr; o_status <= r_st;
        end
    end

    assign o_valid = r_ovalid;
endmodule

// ===== design/chtk_checker.sv =====
// Port-level checks for the hash table, bound to the top level.
module chtk_checker (
    input logic i_clk, i_rst_n, i_valid, o_stall, i_stall, o_valid,
    input logic o_read_value, o_was_present, o_status
);
    // a dropped insert never reports a present key or a set bit
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_was_present && !o_read_value) else $error("full");
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_value)) else $error("hold");
    // a word taken makes the input stall next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("busy");
endmodule

bind chained_hash_table_128bit_key chtk_checker u_chk (.*);
